// ===== sv/fca_pkg.sv =====
// Package for the frame co-adding averager.
// Holds fixed field widths, register indexes and the per-item control struct.
// No dependencies.
`timescale 1ns / 1ps

package fca_pkg;

   localparam int PIX_PORT_W  = 16;
   localparam int SUM_W       = 32;
   localparam int MEAN_W      = 24;
   localparam int FRAMES_W    = 16;
   localparam int PPF_W       = 19;
   localparam int CSR_IDX_W   = 1;
   localparam int PPF_RESET   = 262144;
   localparam int DIV_STEP    = 2;
   localparam int REM_W       = FRAMES_W;

   localparam logic [CSR_IDX_W-1:0] CSR_PIXELS_PER_FRAME = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAMES_TO_ADD    = 1'd1;

   typedef struct packed {
      logic first_frame;
      logic last_frame;
      logic last_pixel;
   } ctl_type;

endpackage

// ===== sv/fca_sequencer.sv =====
// Configuration registers and pixel / frame position counters.
// Classifies each incoming item as first frame, last frame, last pixel.
// Depends on fca_pkg.
`timescale 1ns / 1ps

module fca_sequencer import fca_pkg::*; #(
   parameter int MAX_PIXELS = 262144
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_enable,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [PPF_W-1:0]        csr_wdata,
   input  logic                    accept,
   output logic [((MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1)-1:0] pos,
   output ctl_type                 ctl,
   output logic [FRAMES_W-1:0]     frames
);

   localparam int POS_W      = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int RESET_LEN  = (MAX_PIXELS < PPF_RESET) ? MAX_PIXELS : PPF_RESET;
   localparam int LAST_RESET = RESET_LEN - 1;

   logic [POS_W-1:0]    last_idx_ff, last_idx_in;
   logic [FRAMES_W-1:0] frames_ff, frames_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [FRAMES_W-1:0] frame_ff, frame_in;
   logic [31:0]         len_req;

   always_comb begin
      ctl.first_frame = (frame_ff == '0);
      ctl.last_frame  = (frame_ff >= (frames_ff - FRAMES_W'(1)));
      ctl.last_pixel  = (pos_ff == last_idx_ff);
   end

   assign pos    = pos_ff;
   assign frames = frames_ff;
   assign len_req = 32'(csr_wdata);

   always_comb begin
      last_idx_in = last_idx_ff;
      frames_in   = frames_ff;
      pos_in      = pos_ff;
      frame_in    = frame_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_PIXELS_PER_FRAME: begin
               if (len_req == 32'd0) begin
                  last_idx_in = '0;
               end else if (len_req > 32'(MAX_PIXELS)) begin
                  last_idx_in = POS_W'(MAX_PIXELS - 1);
               end else begin
                  last_idx_in = POS_W'(len_req - 32'd1);
               end
            end
            CSR_FRAMES_TO_ADD: begin
               frames_in = (csr_wdata[FRAMES_W-1:0] == '0) ? FRAMES_W'(1)
                                                            : csr_wdata[FRAMES_W-1:0];
            end
            default: begin
            end
         endcase
         pos_in   = '0;
         frame_in = '0;
      end else if (accept) begin
         if (ctl.last_pixel) begin
            pos_in   = '0;
            frame_in = ctl.last_frame ? '0 : frame_ff + FRAMES_W'(1);
         end else begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_idx_ff <= POS_W'(LAST_RESET);
         frames_ff   <= FRAMES_W'(1);
         pos_ff      <= '0;
         frame_ff    <= '0;
      end else begin
         last_idx_ff <= last_idx_in;
         frames_ff   <= frames_in;
         pos_ff      <= pos_in;
         frame_ff    <= frame_in;
      end
   end

endmodule

// ===== sv/fca_accum.sv =====
// Frame-sized sum store with read-modify-write over two pipeline stages.
// Forwards the most recent write to cover back-to-back hits on one entry.
// Depends on fca_pkg.
`timescale 1ns / 1ps

module fca_accum import fca_pkg::*; #(
   parameter int MAX_PIXELS = 262144,
   parameter int PIXEL_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [PIX_PORT_W-1:0]   in_pixel,
   input  logic [((MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1)-1:0] in_pos,
   input  ctl_type                 in_ctl,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [SUM_W-1:0]        out_sum,
   output logic                    out_end
);

   localparam int POS_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

   logic [SUM_W-1:0]      sums_mem [MAX_PIXELS];

   logic                  v1_ff;
   logic [POS_W-1:0]      pos1_ff;
   logic [PIXEL_BITS-1:0] pix1_ff;
   ctl_type               ctl1_ff;
   logic [SUM_W-1:0]      rd1_ff;

   logic                  v2_ff, v2_in;
   logic [SUM_W-1:0]      sum2_ff;
   logic                  end2_ff;

   logic                  wr_v_ff;
   logic [POS_W-1:0]      wr_addr_ff;
   logic [SUM_W-1:0]      wr_data_ff;

   logic                  en1, en2, load1, wr_en;
   logic [SUM_W-1:0]      base, sum1;

   assign en2      = !v2_ff || out_ready;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;
   assign load1    = en1 && in_valid;
   assign wr_en    = v1_ff && en2;
   assign v2_in    = v1_ff && ctl1_ff.last_frame;

   always_comb begin
      if (ctl1_ff.first_frame) begin
         base = '0;
      end else if (wr_v_ff && (wr_addr_ff == pos1_ff)) begin
         base = wr_data_ff;
      end else begin
         base = rd1_ff;
      end
      sum1 = base + SUM_W'(pix1_ff);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         sums_mem[pos1_ff] <= sum1;
      end
      if (load1) begin
         rd1_ff <= sums_mem[in_pos];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         wr_v_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= in_valid;
         end
         if (en2) begin
            v2_ff <= v2_in;
         end
         if (wr_en) begin
            wr_v_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load1) begin
         pos1_ff <= in_pos;
         pix1_ff <= in_pixel[PIXEL_BITS-1:0];
         ctl1_ff <= in_ctl;
      end
      if (wr_en) begin
         sum2_ff    <= sum1;
         end2_ff    <= ctl1_ff.last_pixel;
         wr_addr_ff <= pos1_ff;
         wr_data_ff <= sum1;
      end
   end

   assign out_valid = v2_ff;
   assign out_sum   = sum2_ff;
   assign out_end   = end2_ff;

endmodule

// ===== sv/fca_divider.sv =====
// Pipelined restoring divider: (sum << FRACTION_BITS) / frames, saturated.
// Resolves DIV_STEP quotient bits in each stage after the input register; the last stage is the output register.
// Depends on fca_pkg.
`timescale 1ns / 1ps

module fca_divider import fca_pkg::*; #(
   parameter int FRACTION_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [SUM_W-1:0]     in_sum,
   input  logic                 in_end,
   input  logic [FRAMES_W-1:0]  divisor,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [MEAN_W-1:0]    out_mean,
   output logic                 out_end
);

   localparam int DVD_W = SUM_W + FRACTION_BITS;
   localparam int HI_W  = DVD_W - MEAN_W;
   localparam int NSTG  = MEAN_W / DIV_STEP;

   logic [DVD_W-1:0]  dividend;
   logic [HI_W-1:0]   hi;
   logic              sat0;

   logic              v_ff   [NSTG+1];
   logic [REM_W-1:0]  rem_ff [NSTG+1];
   logic [MEAN_W-1:0] quo_ff [NSTG+1];
   logic              sat_ff [NSTG+1];
   logic              end_ff [NSTG+1];
   logic [REM_W-1:0]  rem_in [NSTG+1];
   logic [MEAN_W-1:0] quo_in [NSTG+1];
   logic              en     [NSTG+1];

   always_comb begin
      dividend = DVD_W'(in_sum) << FRACTION_BITS;
      hi       = dividend[DVD_W-1:MEAN_W];
      sat0     = (32'(hi) >= 32'(divisor));
   end

   always_comb begin
      logic [REM_W-1:0]  r;
      logic [MEAN_W-1:0] q;
      logic [REM_W:0]    t;
      rem_in[0] = REM_W'(hi);
      quo_in[0] = dividend[MEAN_W-1:0];
      for (int k = 1; k <= NSTG; k++) begin
         r = rem_ff[k-1];
         q = quo_ff[k-1];
         for (int i = 0; i < DIV_STEP; i++) begin
            t = {r, q[MEAN_W-1]};
            q = q << 1;
            if (t >= {1'b0, divisor}) begin
               t    = t - {1'b0, divisor};
               q[0] = 1'b1;
            end
            r = t[REM_W-1:0];
         end
         rem_in[k] = r;
         quo_in[k] = q;
      end
   end

   always_comb begin
      en[NSTG] = !v_ff[NSTG] || out_ready;
      for (int k = NSTG - 1; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign in_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= NSTG; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else begin
         if (en[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k <= NSTG; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         rem_ff[0] <= rem_in[0];
         quo_ff[0] <= quo_in[0];
         sat_ff[0] <= sat0;
         end_ff[0] <= in_end;
      end
      for (int k = 1; k <= NSTG; k++) begin
         if (en[k]) begin
            rem_ff[k] <= rem_in[k];
            quo_ff[k] <= quo_in[k];
            sat_ff[k] <= sat_ff[k-1];
            end_ff[k] <= end_ff[k-1];
         end
      end
   end

   assign out_valid = v_ff[NSTG];
   assign out_mean  = sat_ff[NSTG] ? '1 : quo_ff[NSTG];
   assign out_end   = end_ff[NSTG];

endmodule

// ===== sv/frame_coadd_averager_core.sv =====
// Frame co-adding averager, top level.
// Depends on fca_pkg, fca_sequencer, fca_accum and fca_divider.
//
// Pixels enter in raster order at one item per clock, sustained while rsp_ is
// not back-pressured. Each pixel is added into a frame-sized sum store (one
// read port, one write port); the first frame of a run ignores the stored
// sum, so the store needs no clearing after reset. During the last frame of a
// run every pixel yields one item on rsp_: its sum times 2^FRACTION_BITS
// divided by frames_to_add, truncated and saturated. Each result passes
// through the read-modify-write of the store and the pipelined divider, which
// resolves two quotient bits per stage. Back-pressure on rsp_ stalls the
// pipeline stage by stage without loss. Any csr_ write restarts the run; write
// csr_ only while no items are in flight.
`timescale 1ns / 1ps

module frame_coadd_averager_core import fca_pkg::*; #(
   parameter int MAX_PIXELS    = 262144,
   parameter int PIXEL_BITS    = 16,
   parameter int FRACTION_BITS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [PIX_PORT_W-1:0]  req_pixel,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [MEAN_W-1:0]      rsp_mean_value,
   output logic                   rsp_frame_end,
   input  logic                   csr_write_enable,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [PPF_W-1:0]       csr_wdata
);

   localparam int POS_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

   logic [POS_W-1:0]    pos;
   ctl_type             ctl;
   logic [FRAMES_W-1:0] frames;
   logic                acc_valid, acc_ready, acc_end;
   logic [SUM_W-1:0]    acc_sum;

   fca_sequencer #(
      .MAX_PIXELS (MAX_PIXELS)
   ) u_sequencer (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .accept           (req_valid && req_ready),
      .pos              (pos),
      .ctl              (ctl),
      .frames           (frames)
   );

   fca_accum #(
      .MAX_PIXELS (MAX_PIXELS),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_accum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_pixel  (req_pixel),
      .in_pos    (pos),
      .in_ctl    (ctl),
      .out_valid (acc_valid),
      .out_ready (acc_ready),
      .out_sum   (acc_sum),
      .out_end   (acc_end)
   );

   fca_divider #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (acc_valid),
      .in_ready  (acc_ready),
      .in_sum    (acc_sum),
      .in_end    (acc_end),
      .divisor   (frames),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_mean  (rsp_mean_value),
      .out_end   (rsp_frame_end)
   );

endmodule
